[hdl/pdes_pkg.sv]
// pdes_pkg: shared types, codes and constants of the projectile drag Euler step block.
// Used by pdes_ctrl, pdes_datapath and the top level; depends on nothing.
package pdes_pkg;

    localparam int unsigned CFG_AW = 3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_DRAG   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_WIND_X = 3'd1;
    localparam logic [CFG_AW-1:0] REG_WIND_Y = 3'd2;
    localparam logic [CFG_AW-1:0] REG_WIND_Z = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GRAV_X = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GRAV_Y = 3'd5;
    localparam logic [CFG_AW-1:0] REG_GRAV_Z = 3'd6;
    localparam logic [CFG_AW-1:0] REG_MUZZLE = 3'd7;

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_FIRE  = 2'd1;
    localparam logic [1:0] CMD_HIT   = 2'd2;
    // unused code: state unchanged, result still given
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // datapath operations
    localparam logic [4:0] OP_IDLE   = 5'd0;
    localparam logic [4:0] OP_LOAD   = 5'd1;
    localparam logic [4:0] OP_REL    = 5'd2;
    localparam logic [4:0] OP_SQMUL  = 5'd3;
    localparam logic [4:0] OP_SQACC  = 5'd4;
    localparam logic [4:0] OP_SQINIT = 5'd5;
    localparam logic [4:0] OP_SQSTEP = 5'd6;
    localparam logic [4:0] OP_KMMUL  = 5'd7;
    localparam logic [4:0] OP_KM     = 5'd8;
    localparam logic [4:0] OP_DMUL   = 5'd9;
    localparam logic [4:0] OP_DRAG   = 5'd10;
    localparam logic [4:0] OP_ACC    = 5'd11;
    localparam logic [4:0] OP_AMUL   = 5'd12;
    localparam logic [4:0] OP_VEL    = 5'd13;
    localparam logic [4:0] OP_VMUL   = 5'd14;
    localparam logic [4:0] OP_POS    = 5'd15;
    localparam logic [4:0] OP_FMUL   = 5'd16;
    localparam logic [4:0] OP_FIRE   = 5'd17;
    localparam logic [4:0] OP_HIT    = 5'd18;
    localparam logic [4:0] OP_DINIT  = 5'd19;
    localparam logic [4:0] OP_DSTEP  = 5'd20;
    localparam logic [4:0] OP_OUT    = 5'd21;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 17;
    localparam int unsigned LAST_AXIS  = 2;

    localparam logic [15:0]        SCALE_ONE    = 16'd32768;
    localparam logic signed [33:0] DEPTH_OFFSET = 34'sd19660800;     // 300.0 in Q16.16
    localparam logic [39:0]        SCALE_NUM    = 40'd322122547200;  // 150 * 2^16 * 2^15

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       tick_ok;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -66'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

[hdl/pdes_if.sv]
// pdes_if: channel interfaces of the projectile drag Euler step block (item, result, config).
// Standalone; no package dependency.
interface pdes_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        dt;
    logic               flying;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    modport source (output valid, cmd, dt, flying, start_x, start_y, start_z,
                    dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, cmd, dt, flying, start_x, start_y, start_z,
                  dir_x, dir_y, dir_z, output ready);
endinterface

interface pdes_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        apparent_scale;
    logic               is_fired;
    modport source (output valid, pos_x, pos_y, pos_z, apparent_scale, is_fired,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, apparent_scale, is_fired,
                  output ready);
endinterface

interface pdes_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

[hdl/projectile_drag_euler_step_unit.sv]
// projectile_drag_euler_step_unit: top level of the projectile drag Euler step block.
// Depends on pdes_pkg, pdes_if, pdes_ctrl and pdes_datapath.
//
// Usage: one item beat in on item, one result beat out on result for every item.
// Config writes arrive on cfg (always ready) and should only be issued while idle.
// Items are worked one at a time; item.ready is high only between items.
// Work from item accept to result valid, as laid out by the sequencer's steps:
//   tick (fired, flying) : |v-w|^2, 32-step bit-serial square root, per-axis steps
//                          on the shared multiplier, 17-step divide
//   fire                 : per-axis steps on the shared multiplier, 17-step divide
//   hit                  : restore of the saved position, 17-step divide
//   other (idle tick, unused code) : 17-step divide only
// The next item is accepted in the cycle after the result is loaded, while the result
// still waits in its output register. If the receiver stalls, that result holds;
// a following item is worked up to the end of its divide and then waits for it.
// Reset (rst_n low, asynchronous) clears position, saved position, velocity, the
// fired flag and all config registers to zero and drops result.valid.
module projectile_drag_euler_step_unit (
    input logic            clk,
    input logic            rst_n,
    pdes_item_if.sink      item,
    pdes_result_if.source  result,
    pdes_cfg_if.sink       cfg
);
    pdes_pkg::dp_cmd_t  cmd;
    pdes_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    pdes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pdes_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg.valid),
        .cfg_addr       (cfg.addr),
        .cfg_data       (cfg.data),
        .item_cmd       (item.cmd),
        .item_dt        (item.dt),
        .item_flying    (item.flying),
        .item_start_x   (item.start_x),
        .item_start_y   (item.start_y),
        .item_start_z   (item.start_z),
        .item_dir_x     (item.dir_x),
        .item_dir_y     (item.dir_y),
        .item_dir_z     (item.dir_z),
        .pos_x          (result.pos_x),
        .pos_y          (result.pos_y),
        .pos_z          (result.pos_z),
        .apparent_scale (result.apparent_scale),
        .is_fired       (result.is_fired)
    );

endmodule

[hdl/pdes_ctrl.sv]
// pdes_ctrl: sequencer that steps the datapath through one item's operations.
// Depends on pdes_pkg (op codes, command and status structs).
module pdes_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pdes_pkg::dp_cmd_t  cmd,
    input  pdes_pkg::dp_stat_t stat
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_REL    = 5'd2;
    localparam logic [4:0] S_SQMUL  = 5'd3;
    localparam logic [4:0] S_SQACC  = 5'd4;
    localparam logic [4:0] S_SQINIT = 5'd5;
    localparam logic [4:0] S_SQSTEP = 5'd6;
    localparam logic [4:0] S_KMMUL  = 5'd7;
    localparam logic [4:0] S_KM     = 5'd8;
    localparam logic [4:0] S_DMUL   = 5'd9;
    localparam logic [4:0] S_DRAG   = 5'd10;
    localparam logic [4:0] S_ACC    = 5'd11;
    localparam logic [4:0] S_AMUL   = 5'd12;
    localparam logic [4:0] S_VEL    = 5'd13;
    localparam logic [4:0] S_VMUL   = 5'd14;
    localparam logic [4:0] S_POS    = 5'd15;
    localparam logic [4:0] S_FMUL   = 5'd16;
    localparam logic [4:0] S_FIRE   = 5'd17;
    localparam logic [4:0] S_HIT    = 5'd18;
    localparam logic [4:0] S_DINIT  = 5'd19;
    localparam logic [4:0] S_DSTEP  = 5'd20;
    localparam logic [4:0] S_DONE   = 5'd21;

    logic [4:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_axis;

    assign last_axis = (idx_reg == 2'(pdes_pkg::LAST_AXIS));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = pdes_pkg::OP_IDLE;
        cmd.idx        = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = pdes_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                idx_next = 2'd0;
                if (stat.cmd == pdes_pkg::CMD_TICK && stat.tick_ok)
                    state_next = S_REL;
                else if (stat.cmd == pdes_pkg::CMD_FIRE)
                    state_next = S_FMUL;
                else if (stat.cmd == pdes_pkg::CMD_HIT)
                    state_next = S_HIT;
                else
                    state_next = S_DINIT;
            end
            S_REL:
            begin
                cmd.op     = pdes_pkg::OP_REL;
                state_next = S_SQMUL;
            end
            S_SQMUL:
            begin
                cmd.op     = pdes_pkg::OP_SQMUL;
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                cmd.op = pdes_pkg::OP_SQACC;
                if (last_axis)
                begin
                    idx_next   = 2'd0;
                    state_next = S_SQINIT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_SQMUL;
                end
            end
            S_SQINIT:
            begin
                cmd.op     = pdes_pkg::OP_SQINIT;
                cnt_next   = 5'd0;
                state_next = S_SQSTEP;
            end
            S_SQSTEP:
            begin
                cmd.op   = pdes_pkg::OP_SQSTEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(pdes_pkg::SQRT_STEPS - 1))
                    state_next = S_KMMUL;
            end
            S_KMMUL:
            begin
                cmd.op     = pdes_pkg::OP_KMMUL;
                state_next = S_KM;
            end
            S_KM:
            begin
                cmd.op     = pdes_pkg::OP_KM;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = pdes_pkg::OP_DMUL;
                state_next = S_DRAG;
            end
            S_DRAG:
            begin
                cmd.op     = pdes_pkg::OP_DRAG;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = pdes_pkg::OP_ACC;
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.op     = pdes_pkg::OP_AMUL;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                cmd.op     = pdes_pkg::OP_VEL;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd.op     = pdes_pkg::OP_VMUL;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.op = pdes_pkg::OP_POS;
                if (last_axis)
                    state_next = S_DINIT;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_DMUL;
                end
            end
            S_FMUL:
            begin
                cmd.op     = pdes_pkg::OP_FMUL;
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                cmd.op = pdes_pkg::OP_FIRE;
                if (last_axis)
                    state_next = S_DINIT;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_FMUL;
                end
            end
            S_HIT:
            begin
                cmd.op     = pdes_pkg::OP_HIT;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = pdes_pkg::OP_DINIT;
                cnt_next   = 5'd0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op   = pdes_pkg::OP_DSTEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(pdes_pkg::DIV_STEPS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = pdes_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/pdes_datapath.sv]
// pdes_datapath: config and state registers, shared 33x33 multiplier, bit-serial square
// root and restoring divider of the projectile step. Depends on pdes_pkg.
module pdes_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pdes_pkg::dp_cmd_t   cmd,
    output pdes_pkg::dp_stat_t  stat,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [31:0]         cfg_data,
    input  logic [1:0]          item_cmd,
    input  logic [15:0]         item_dt,
    input  logic                item_flying,
    input  logic signed [31:0]  item_start_x,
    input  logic signed [31:0]  item_start_y,
    input  logic signed [31:0]  item_start_z,
    input  logic signed [17:0]  item_dir_x,
    input  logic signed [17:0]  item_dir_y,
    input  logic signed [17:0]  item_dir_z,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic [15:0]         apparent_scale,
    output logic                is_fired
);
    // configuration
    logic [31:0]        drag_reg;
    logic signed [31:0] wind_reg [3];
    logic signed [31:0] grav_reg [3];
    logic [30:0]        muzzle_reg;

    // captured item
    logic [1:0]         icmd_reg;
    logic [15:0]        dt_reg;
    logic               flying_reg;
    logic signed [31:0] start_reg [3];
    logic signed [17:0] dir_reg [3];

    // projectile state
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] vel_reg [3];
    logic               fired_reg;

    // work registers
    logic signed [31:0] rel_reg [3];
    logic signed [65:0] prod_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        rad_reg;
    logic [33:0]        srem_reg;
    logic [31:0]        root_reg;
    logic [31:0]        km_reg;
    logic signed [31:0] dragv_reg;
    logic signed [31:0] acc_reg;
    logic               dneg_reg;
    logic               dzero_reg;
    logic [39:0]        drem_reg;
    logic [47:0]        dsh_reg;
    logic [16:0]        q_reg;

    // result register
    logic signed [31:0] res_pos_reg [3];
    logic [15:0]        res_scale_reg;
    logic               res_fired_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [31:0] rel_w [3];
    logic signed [31:0] rel_i;
    logic [32:0]        abs_rel;
    logic [64:0]        km_sum;
    logic [31:0]        km_w;
    logic [63:0]        p_sum;
    logic [47:0]        p_w;
    logic               p_big;
    logic signed [31:0] drag_w;
    logic signed [65:0] rs_w;
    logic [35:0]        sq_cand, sq_trial;
    logic               sq_ge;
    logic signed [33:0] dist_w;
    logic               div_ge;
    logic [15:0]        scale_w;

    assign rel_i   = rel_reg[cmd.idx];
    assign abs_rel = rel_i[31] ? 33'(-{rel_i[31], rel_i}) : {1'b0, rel_i};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pdes_pkg::OP_SQMUL:
            begin
                mul_a = 33'(rel_i);
                mul_b = 33'(rel_i);
            end
            pdes_pkg::OP_KMMUL:
            begin
                mul_a = {1'b0, drag_reg};
                mul_b = {1'b0, root_reg};
            end
            pdes_pkg::OP_DMUL:
            begin
                mul_a = {1'b0, km_reg};
                mul_b = abs_rel;
            end
            pdes_pkg::OP_AMUL:
            begin
                mul_a = 33'(acc_reg);
                mul_b = {17'd0, dt_reg};
            end
            pdes_pkg::OP_VMUL:
            begin
                mul_a = 33'(vel_reg[cmd.idx]);
                mul_b = {17'd0, dt_reg};
            end
            pdes_pkg::OP_FMUL:
            begin
                mul_a = 33'(dir_reg[cmd.idx]);
                mul_b = {2'd0, muzzle_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rel_w[i] = pdes_pkg::sat32(66'(vel_reg[i]) - 66'(wind_reg[i]));
    end

    // k*|v-w| back to Q16.16, clamped
    assign km_sum = {1'b0, prod_reg[63:0]} + 65'd8388608;
    assign km_w   = (|km_sum[64:56]) ? 32'hFFFFFFFF : km_sum[55:24];

    // drag magnitude, rounded half away from zero then saturated by sign
    assign p_sum  = {1'b0, prod_reg[62:0]} + 64'd32768;
    assign p_w    = p_sum[63:16];
    assign p_big  = |p_w[47:31];
    assign drag_w = rel_i[31] ? (p_big ? 32'sh80000000 : -$signed(p_w[31:0]))
                              : (p_big ? 32'sh7FFFFFFF : $signed(p_w[31:0]));

    // round to nearest, ties up
    assign rs_w = (prod_reg + 66'sd32768) >>> 16;

    assign sq_cand  = {srem_reg, rad_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_cand >= sq_trial);

    assign dist_w = 34'(pos_reg[2]) + pdes_pkg::DEPTH_OFFSET;
    assign div_ge = ({8'd0, drem_reg} >= dsh_reg);

    always_comb
    begin
        if (dneg_reg)
            scale_w = 16'd0;
        else if (dzero_reg || q_reg > 17'(pdes_pkg::SCALE_ONE))
            scale_w = pdes_pkg::SCALE_ONE;
        else
            scale_w = q_reg[15:0];
    end

    // configuration and projectile state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg   <= '0;
            muzzle_reg <= '0;
            fired_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                wind_reg[i] <= '0;
                grav_reg[i] <= '0;
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    pdes_pkg::REG_DRAG:   drag_reg    <= cfg_data;
                    pdes_pkg::REG_WIND_X: wind_reg[0] <= cfg_data;
                    pdes_pkg::REG_WIND_Y: wind_reg[1] <= cfg_data;
                    pdes_pkg::REG_WIND_Z: wind_reg[2] <= cfg_data;
                    pdes_pkg::REG_GRAV_X: grav_reg[0] <= cfg_data;
                    pdes_pkg::REG_GRAV_Y: grav_reg[1] <= cfg_data;
                    pdes_pkg::REG_GRAV_Z: grav_reg[2] <= cfg_data;
                    pdes_pkg::REG_MUZZLE: muzzle_reg  <= cfg_data[30:0];
                    default:              drag_reg    <= drag_reg;
                endcase
            end
            case (cmd.op)
                pdes_pkg::OP_VEL:
                    vel_reg[cmd.idx] <= pdes_pkg::sat32(66'(vel_reg[cmd.idx]) + rs_w);
                pdes_pkg::OP_POS:
                begin
                    prev_reg[cmd.idx] <= pos_reg[cmd.idx];
                    pos_reg[cmd.idx]  <= pdes_pkg::sat32(66'(pos_reg[cmd.idx]) + rs_w);
                end
                pdes_pkg::OP_FIRE:
                begin
                    vel_reg[cmd.idx] <= pdes_pkg::sat32(rs_w);
                    pos_reg[cmd.idx] <= start_reg[cmd.idx];
                    fired_reg        <= 1'b1;
                end
                pdes_pkg::OP_HIT:
                begin
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= prev_reg[i];
                end
                default:
                begin
                    fired_reg <= fired_reg;
                end
            endcase
        end
    end

    // item capture, work registers and result register
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pdes_pkg::OP_LOAD:
            begin
                icmd_reg     <= item_cmd;
                dt_reg       <= item_dt;
                flying_reg   <= item_flying;
                start_reg[0] <= item_start_x;
                start_reg[1] <= item_start_y;
                start_reg[2] <= item_start_z;
                dir_reg[0]   <= item_dir_x;
                dir_reg[1]   <= item_dir_y;
                dir_reg[2]   <= item_dir_z;
            end
            pdes_pkg::OP_REL:
            begin
                for (int i = 0; i < 3; i++)
                    rel_reg[i] <= rel_w[i];
                sum_reg <= '0;
            end
            pdes_pkg::OP_SQMUL,
            pdes_pkg::OP_KMMUL,
            pdes_pkg::OP_DMUL,
            pdes_pkg::OP_AMUL,
            pdes_pkg::OP_VMUL,
            pdes_pkg::OP_FMUL:
                prod_reg <= mul_p;
            pdes_pkg::OP_SQACC:
                sum_reg <= sum_reg + prod_reg[63:0];
            pdes_pkg::OP_SQINIT:
            begin
                rad_reg  <= sum_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            pdes_pkg::OP_SQSTEP:
            begin
                // two radicand bits per step, one root bit out
                rad_reg  <= {rad_reg[61:0], 2'b00};
                srem_reg <= sq_ge ? 34'(sq_cand - sq_trial) : sq_cand[33:0];
                root_reg <= {root_reg[30:0], sq_ge};
            end
            pdes_pkg::OP_KM:
                km_reg <= km_w;
            pdes_pkg::OP_DRAG:
                dragv_reg <= drag_w;
            pdes_pkg::OP_ACC:
                acc_reg <= pdes_pkg::sat32(66'(grav_reg[cmd.idx]) - 66'(dragv_reg));
            pdes_pkg::OP_DINIT:
            begin
                dneg_reg  <= dist_w[33];
                dzero_reg <= (dist_w == 34'sd0);
                drem_reg  <= pdes_pkg::SCALE_NUM + {9'd0, dist_w[31:1]};
                dsh_reg   <= {dist_w[31:0], 16'd0};
                q_reg     <= '0;
            end
            pdes_pkg::OP_DSTEP:
            begin
                if (div_ge)
                    drem_reg <= drem_reg - dsh_reg[39:0];
                dsh_reg <= {1'b0, dsh_reg[47:1]};
                q_reg   <= {q_reg[15:0], div_ge};
            end
            pdes_pkg::OP_OUT:
            begin
                for (int i = 0; i < 3; i++)
                    res_pos_reg[i] <= pos_reg[i];
                res_scale_reg <= scale_w;
                res_fired_reg <= fired_reg;
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign stat.cmd       = icmd_reg;
    assign stat.tick_ok   = fired_reg & flying_reg;
    assign pos_x          = res_pos_reg[0];
    assign pos_y          = res_pos_reg[1];
    assign pos_z          = res_pos_reg[2];
    assign apparent_scale = res_scale_reg;
    assign is_fired       = res_fired_reg;

endmodule

[hdl/pdes_checker.sv]
// pdes_checker: port-level assertions for projectile_drag_euler_step_unit, with its bind.
// Depends only on the top level's ports.
module pdes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_pos_x,
    input logic [15:0] res_scale
);
    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pos_x) && $stable(res_scale))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops right after an accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in work");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_scale <= 16'd32768)
        else $error("apparent scale above one");

    // in the cycle after reset is seen the block must show idle
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !res_valid && item_ready)
        else $error("block not idle in reset");

endmodule

bind projectile_drag_euler_step_unit pdes_checker u_pdes_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_pos_x  (result.pos_x),
    .res_scale  (result.apparent_scale)
);

[bench/projectile_drag_euler_step_unit_test.sv]
// Testbench for projectile_drag_euler_step_unit: random and directed fire/tick/hit
// items checked against an in-bench fixed-point flight predictor. Depends on pdes_pkg, pdes_if.
`timescale 1ns / 1ps
module projectile_drag_euler_step_unit_test;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        scale;
        logic               fired;
    } flight_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    pdes_item_if   item ();
    pdes_result_if result ();
    pdes_cfg_if    cfg ();

    projectile_drag_euler_step_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // predictor state
    logic [31:0]        k_drag;
    logic signed [31:0] wind [3];
    logic signed [31:0] grav [3];
    logic [30:0]        muzzle;
    logic signed [31:0] pos [3];
    logic signed [31:0] prev_pos [3];
    logic signed [31:0] vel [3];
    logic               fired;

    flight_out_t pending_pos [$];
    int          errors = 0;
    int          idle_pct = 37;

    function automatic logic signed [31:0] clip32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // round to nearest, ties toward plus infinity (arithmetic shift floor after bias)
    function automatic logic signed [65:0] round_shr(input logic signed [65:0] x, input int s);
        logic signed [65:0] b;
        b = x + (66'sd1 <<< (s - 1));
        return b >>> s;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] depth_scale(input logic signed [31:0] z);
        logic signed [63:0] d;
        logic [63:0] q;
        d = 64'(z) + 64'sd19660800;
        if (d < 0) return 16'd0;
        if (d == 0) return 16'd32768;
        q = (64'd322122547200 + (64'(d) >> 1)) / 64'(d);
        return (q > 64'd32768) ? 16'd32768 : q[15:0];
    endfunction

    task automatic euler_step(input logic [15:0] dt);
        logic signed [65:0] rel [3];
        logic [63:0] sum, mag, a, p;
        logic [127:0] kmw;
        logic [63:0] km;
        logic signed [65:0] drag, acc;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            rel[i] = 66'(clip32(66'(vel[i]) - 66'(wind[i])));
            sum = sum + 64'(rel[i] * rel[i]);
        end
        mag = root64(sum);
        kmw = (128'(k_drag) * 128'(mag) + (128'd1 << 23)) >> 24;
        km = (kmw > 128'hFFFFFFFF) ? 64'hFFFFFFFF : kmw[63:0];
        for (int i = 0; i < 3; i++) begin
            a = rel[i] < 0 ? 64'(-rel[i]) : 64'(rel[i]);
            kmw = (128'(km) * 128'(a) + (128'd1 << 15)) >> 16;
            p = (kmw > (128'd1 << 32)) ? (64'd1 << 32) : kmw[63:0];
            drag = rel[i] < 0 ? -66'(p) : 66'(p);
            drag = 66'(clip32(drag));
            acc = 66'(clip32(66'(grav[i]) - drag));
            vel[i] = clip32(66'(vel[i]) + round_shr(acc * 66'(dt), 16));
        end
        for (int i = 0; i < 3; i++) begin
            prev_pos[i] = pos[i];
            pos[i] = clip32(66'(pos[i]) + round_shr(66'(vel[i]) * 66'(dt), 16));
        end
    endtask

    task automatic predict_flight(input logic [1:0] c, input logic [15:0] dt, input logic fl,
                                  input logic signed [31:0] s [3],
                                  input logic signed [17:0] d [3]);
        flight_out_t e;
        if (c == pdes_pkg::CMD_TICK) begin
            if (fired && fl) euler_step(dt);
        end else if (c == pdes_pkg::CMD_FIRE) begin
            for (int i = 0; i < 3; i++) begin
                pos[i] = s[i];
                vel[i] = clip32(round_shr(66'(d[i]) * 66'({1'b0, muzzle}), 16));
            end
            fired = 1'b1;
        end else if (c == pdes_pkg::CMD_HIT) begin
            for (int i = 0; i < 3; i++) pos[i] = prev_pos[i];
        end
        e.px = pos[0];
        e.py = pos[1];
        e.pz = pos[2];
        e.scale = depth_scale(pos[2]);
        e.fired = fired;
        pending_pos.push_back(e);
    endtask

    // valid stays up after a beat until the next idle cycle or drain
    task automatic send_item(input logic [1:0] c, input logic [15:0] dt, input logic fl,
                             input logic signed [31:0] s [3], input logic signed [17:0] d [3]);
        while ($urandom_range(99) < idle_pct) begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid   <= 1'b1;
        item.cmd     <= c;
        item.dt      <= dt;
        item.flying  <= fl;
        item.start_x <= s[0];
        item.start_y <= s[1];
        item.start_z <= s[2];
        item.dir_x   <= d[0];
        item.dir_y   <= d[1];
        item.dir_z   <= d[2];
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        predict_flight(c, dt, fl, s, d);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            pdes_pkg::REG_DRAG:   k_drag = v;
            pdes_pkg::REG_WIND_X: wind[0] = v;
            pdes_pkg::REG_WIND_Y: wind[1] = v;
            pdes_pkg::REG_WIND_Z: wind[2] = v;
            pdes_pkg::REG_GRAV_X: grav[0] = v;
            pdes_pkg::REG_GRAV_Y: grav[1] = v;
            pdes_pkg::REG_GRAV_Z: grav[2] = v;
            pdes_pkg::REG_MUZZLE: muzzle = v[30:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] k, input logic [31:0] w, input logic [31:0] g,
                             input logic [31:0] m);
        drain();
        write_reg(pdes_pkg::REG_DRAG, k);
        write_reg(pdes_pkg::REG_WIND_X, w);
        write_reg(pdes_pkg::REG_WIND_Y, -w);
        write_reg(pdes_pkg::REG_WIND_Z, w >>> 1);
        write_reg(pdes_pkg::REG_GRAV_X, g >>> 2);
        write_reg(pdes_pkg::REG_GRAV_Y, g);
        write_reg(pdes_pkg::REG_GRAV_Z, -g);
        write_reg(pdes_pkg::REG_MUZZLE, m);
        cfg.valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        flight_out_t e;
        if (rst_n && result.valid && result.ready) begin
            if (pending_pos.size() == 0) begin
                $display("%0t: result beat with none expected: %h %h %h", $time,
                         result.pos_x, result.pos_y, result.pos_z);
                errors++;
            end else begin
                e = pending_pos.pop_front();
                if (result.pos_x !== e.px || result.pos_y !== e.py || result.pos_z !== e.pz
                    || result.apparent_scale !== e.scale || result.is_fired !== e.fired) begin
                    $display("%0t: mismatch exp %h %h %h %h %b act %h %h %h %h %b", $time,
                             e.px, e.py, e.pz, e.scale, e.fired, result.pos_x, result.pos_y,
                             result.pos_z, result.apparent_scale, result.is_fired);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) result.ready <= ($urandom_range(99) >= idle_pct);

    task automatic rand_item(input int tick_bias);
        logic signed [31:0] s [3];
        logic signed [17:0] d [3];
        logic [1:0] c;
        int r;
        r = $urandom_range(99);
        c = r < tick_bias ? pdes_pkg::CMD_TICK : (r < tick_bias + 8 ? pdes_pkg::CMD_FIRE :
            (r < 98 ? pdes_pkg::CMD_HIT : pdes_pkg::CMD_SPARE));
        for (int i = 0; i < 3; i++) begin
            s[i] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(40000000)) - 20000000;
            d[i] = ($urandom_range(7) == 0) ? 18'($urandom) : 18'($signed($urandom_range(131072)) - 65536);
        end
        send_item(c, 16'($urandom), $urandom_range(9) != 0, s, d);
    endtask

    task automatic test_directed();
        logic signed [31:0] s [3];
        logic signed [17:0] d [3];
        s = '{0, 0, 0};
        d = '{18'sd65536, 18'sd0, -18'sd65536};
        send_item(pdes_pkg::CMD_TICK, 16'hFFFF, 1'b1, s, d);
        send_item(pdes_pkg::CMD_HIT, 16'd0, 1'b0, s, d);
        send_item(pdes_pkg::CMD_SPARE, 16'd0, 1'b1, s, d);
        write_all(32'h0100_0000, 32'sh0002_0000, 32'shFFF6_0000, 32'h0064_0000);
        send_item(pdes_pkg::CMD_FIRE, 16'd0, 1'b0, s, d);
        send_item(pdes_pkg::CMD_TICK, 16'h0400, 1'b0, s, d);
        repeat (4) send_item(pdes_pkg::CMD_TICK, 16'h0400, 1'b1, s, d);
        send_item(pdes_pkg::CMD_HIT, 16'd0, 1'b1, s, d);
        s = '{32'sh7FFFFFFF, 32'sh80000000, -32'sd19660800};
        d = '{18'sh1FFFF, -18'sh20000, 18'sd0};
        send_item(pdes_pkg::CMD_FIRE, 16'd0, 1'b1, s, d);
        send_item(pdes_pkg::CMD_TICK, 16'hFFFF, 1'b1, s, d);
        send_item(pdes_pkg::CMD_TICK, 16'hFFFF, 1'b1, s, d);
        s = '{0, 0, -32'sd19660801};
        send_item(pdes_pkg::CMD_FIRE, 16'd0, 1'b1, s, d);
        s = '{0, 0, 32'sh7FFFFFFF};
        send_item(pdes_pkg::CMD_FIRE, 16'd0, 1'b1, s, d);
        send_item(pdes_pkg::CMD_TICK, 16'd1, 1'b1, s, d);
        send_item(pdes_pkg::CMD_SPARE, 16'hFFFF, 1'b1, s, d);
    endtask

    task automatic test_extreme_config();
        write_all(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (60) rand_item(80);
        write_all(32'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0);
        repeat (60) rand_item(80);
    endtask

    task automatic test_random_flight();
        for (int ph = 0; ph < 7; ph++) begin
            write_all($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                      $signed($urandom_range(32'h000A_0000)) - 32'sh0005_0000,
                      $signed($urandom_range(32'h0014_0000)) - 32'sh000A_0000,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000));
            idle_pct = (ph == 3) ? 0 : 37;
            repeat (200) rand_item(82);
        end
        idle_pct = 37;
    endtask

    initial begin
        item.valid = 1'b0;
        item.cmd = pdes_pkg::CMD_TICK;
        item.dt = '0;
        item.flying = 1'b0;
        item.start_x = '0;
        item.start_y = '0;
        item.start_z = '0;
        item.dir_x = '0;
        item.dir_y = '0;
        item.dir_z = '0;
        cfg.valid = 1'b0;
        cfg.addr = '0;
        cfg.data = '0;
        result.ready = 1'b0;
        k_drag = 0;
        muzzle = 0;
        fired = 1'b0;
        for (int i = 0; i < 3; i++) begin
            wind[i] = 0;
            grav[i] = 0;
            pos[i] = 0;
            prev_pos[i] = 0;
            vel[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_config();
        test_random_flight();
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[projectile_drag_euler_step_unit.f]
hdl/pdes_pkg.sv
hdl/pdes_if.sv
hdl/pdes_ctrl.sv
hdl/pdes_datapath.sv
hdl/projectile_drag_euler_step_unit.sv
hdl/pdes_checker.sv
bench/projectile_drag_euler_step_unit_test.sv
